FILE: rtl/m2sc_pkg.sv
// shared types, constants and result builder for the mpeg2 start code scanner
package m2sc_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int RES_DEPTH       = 4;
  localparam int RES_PTR_W       = $clog2(RES_DEPTH);
  localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);

  localparam logic [23:0] PREFIX_PATTERN = 24'h000001;
  localparam logic [7:0]  CODE_PICTURE   = 8'h00;
  localparam logic [7:0]  CODE_SLICE_LO  = 8'h01;
  localparam logic [7:0]  CODE_SLICE_HI  = 8'hAF;
  localparam logic [7:0]  CODE_SEQ_HDR   = 8'hB3;
  localparam logic [7:0]  CODE_EXT       = 8'hB5;

  localparam logic [2:0] KIND_OTHER   = 3'd0;
  localparam logic [2:0] KIND_SEQ_HDR = 3'd1;
  localparam logic [2:0] KIND_EXT     = 3'd2;
  localparam logic [2:0] KIND_SLICE   = 3'd3;
  localparam logic [2:0] KIND_PICTURE = 3'd4;

  typedef struct packed {
    logic [7:0]  code_value;
    logic [15:0] code_offset;
    logic [2:0]  code_kind;
    logic [3:0]  extension_id;
    logic [11:0] picture_width;
    logic [1:0]  width_extension;
    logic [1:0]  height_extension;
    logic [4:0]  quant_scale;
    logic        intra_slice;
    logic        truncated;
    logic        last_in_run;
  } res_t;

  function automatic logic is_slice(input logic [7:0] code, input logic key);
    return key && (code >= CODE_SLICE_LO) && (code <= CODE_SLICE_HI);
  endfunction

  // field bytes that follow the code byte
  function automatic logic [1:0] fields_needed(input logic [7:0] code, input logic key);
    logic [1:0] n;
    n = 2'd0;
    if (code == CODE_SEQ_HDR) n = 2'd2;
    else if (code == CODE_EXT) n = 2'd3;
    else if (is_slice(code, key)) n = 2'd1;
    return n;
  endfunction

  function automatic res_t make_result(input logic [7:0] code, input logic [15:0] off,
                                       input logic [23:0] fields, input logic key,
                                       input logic trunc);
    res_t r;
    logic [7:0] b0, b1, b2;
    b0 = fields[7:0];
    b1 = fields[15:8];
    b2 = fields[23:16];
    r = '0;
    r.code_value  = code;
    r.code_offset = off;
    if (code == CODE_SEQ_HDR) begin
      r.code_kind     = KIND_SEQ_HDR;
      r.picture_width = {b0, b1[7:4]};
    end else if (code == CODE_EXT) begin
      r.code_kind        = KIND_EXT;
      r.extension_id     = b0[3:0];
      r.width_extension  = {b1[0], b2[7]};
      r.height_extension = b2[6:5];
    end else if (is_slice(code, key)) begin
      r.code_kind   = KIND_SLICE;
      r.quant_scale = b0[7:3];
      r.intra_slice = b0[2];
    end else if (key && code == CODE_PICTURE) begin
      r.code_kind = KIND_PICTURE;
    end
    r.truncated = trunc;
    return r;
  endfunction

endpackage

FILE: rtl/mpeg2_start_code_scanner.sv
// mpeg2 start code scanner top level: prefix search, field capture and result queue
//
// channel  dir  tdata                    tuser                     tlast
// in_      in   data_byte [7:0]          key_frame [0]             end_of_payload
// out_     out  code/offset/fields [55:0] code_kind [2:0], trunc [3] last_in_run
//
// one input beat per cycle while in_tready is high; each beat is scanned in the cycle it is accepted
// a beat yields zero to two result beats, which enter a four-entry result queue
// results are registered in the queue and reach out_ in order behind any earlier results
// in_tready is high while at least two queue entries are free
// rst_n clears the scan state and empties the queue
module mpeg2_start_code_scanner
  import m2sc_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [0:0]  in_tuser,   // key_frame
  input  logic        in_tlast,   // end_of_payload
  output logic        out_tvalid,
  input  logic        out_tready,
  // code_value, code_offset, extension_id, picture_width, width_extension,
  // height_extension, quant_scale, intra_slice, zero pad
  output logic [55:0] out_tdata,
  output logic [3:0]  out_tuser,  // code_kind, truncated
  output logic        out_tlast   // last_in_run
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] o);
    logic [OFFSET_BITS+15:0] t;
    t = {16'b0, o};
    return t[15:0];
  endfunction

  // scan state
  logic [23:0]            recent_r, recent_nxt;
  logic [1:0]             seen_r, seen_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  logic [7:0]             pend_code_r, pend_code_nxt;
  logic [OFFSET_BITS-1:0] pend_off_r, pend_off_nxt;
  logic [23:0]            pend_fields_r, pend_fields_nxt;
  logic [1:0]             pend_cnt_r, pend_cnt_nxt;

  // result queue
  res_t                   queue_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0]   cnt_r, cnt_nxt;

  logic       accept, pop;
  logic [7:0] b;
  logic       key, eop;

  logic [3:0] cand_v;
  res_t       cand [4];
  res_t       res0, res1;
  logic [1:0] nwr;

  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;
  assign b         = in_tdata;
  assign key       = in_tuser[0];
  assign eop       = in_tlast;
  assign in_tready = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    logic [1:0]             need1, need2, idx;
    logic [23:0]            fields1;
    logic [1:0]             cnt1;
    logic                   emit1, pre, pre_end;
    logic [OFFSET_BITS-1:0] off2, off4;
    logic [2:0]             n;

    // collect a field byte for a waiting report
    need1   = fields_needed(pend_code_r, key);
    idx     = need1 - pend_cnt_r;
    fields1 = pend_fields_r;
    if (pend_vld_r && need1 >= pend_cnt_r) begin
      unique case (idx)
        2'd0:    fields1[7:0]   = b;
        2'd1:    fields1[15:8]  = b;
        2'd2:    fields1[23:16] = b;
        default: fields1        = pend_fields_r;
      endcase
    end
    cnt1  = (pend_cnt_r != 2'd0) ? pend_cnt_r - 2'd1 : 2'd0;
    emit1 = pend_vld_r && (cnt1 == 2'd0);

    cand_v[0] = emit1;
    cand[0]   = make_result(pend_code_r, off16(pend_off_r), fields1, key, 1'b0);

    pend_vld_nxt    = pend_vld_r && !emit1;
    pend_code_nxt   = pend_code_r;
    pend_off_nxt    = pend_off_r;
    pend_fields_nxt = emit1 ? 24'd0 : fields1;
    pend_cnt_nxt    = pend_vld_r ? cnt1 : pend_cnt_r;

    // code byte after a complete prefix
    pre   = (seen_r == 2'd3) && (recent_r == PREFIX_PATTERN);
    off2  = (offset_r == OFF_MAX) ? OFF_MAX : offset_r - OFFSET_BITS'(3);
    need2 = fields_needed(b, key);
    cand_v[1] = pre && (need2 == 2'd0);
    cand[1]   = make_result(b, off16(off2), 24'd0, key, 1'b0);
    if (pre && need2 != 2'd0) begin
      pend_vld_nxt    = 1'b1;
      pend_code_nxt   = b;
      pend_off_nxt    = off2;
      pend_fields_nxt = 24'd0;
      pend_cnt_nxt    = need2;
    end

    recent_nxt = {recent_r[15:0], b};
    seen_nxt   = (seen_r != 2'd3) ? seen_r + 2'd1 : seen_r;

    // end of payload flush
    pre_end   = (seen_nxt == 2'd3) && (recent_nxt == PREFIX_PATTERN);
    off4      = (offset_r == OFF_MAX) ? OFF_MAX : offset_r - OFFSET_BITS'(2);
    cand_v[2] = eop && pend_vld_nxt;
    cand[2]   = make_result(pend_code_nxt, off16(pend_off_nxt), pend_fields_nxt, key, 1'b1);
    cand_v[3] = eop && pre_end;
    cand[3]   = make_result(CODE_PICTURE, off16(off4), 24'd0, key, 1'b1);

    if (eop) begin
      recent_nxt      = 24'd0;
      seen_nxt        = 2'd0;
      offset_nxt      = '0;
      pend_vld_nxt    = 1'b0;
      pend_code_nxt   = 8'd0;
      pend_off_nxt    = '0;
      pend_fields_nxt = 24'd0;
      pend_cnt_nxt    = 2'd0;
    end else begin
      offset_nxt = (offset_r != OFF_MAX) ? offset_r + OFFSET_BITS'(1) : offset_r;
    end

    // keep the first two results in order
    res0 = cand[0];
    res1 = cand[0];
    n    = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        if (n == 3'd0) res0 = cand[i];
        else if (n == 3'd1) res1 = cand[i];
        n = n + 3'd1;
      end
    end
    nwr = (n > 3'd2) ? 2'd2 : n[1:0];
    res0.last_in_run = (nwr == 2'd1);
    res1.last_in_run = 1'b1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) cnt_nxt = cnt_nxt + RES_CNT_W'(nwr);
    if (pop) cnt_nxt = cnt_nxt - RES_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r      <= 24'd0;
      seen_r        <= 2'd0;
      offset_r      <= '0;
      pend_vld_r    <= 1'b0;
      pend_cnt_r    <= 2'd0;
      pend_fields_r <= 24'd0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (accept) begin
        recent_r      <= recent_nxt;
        seen_r        <= seen_nxt;
        offset_r      <= offset_nxt;
        pend_vld_r    <= pend_vld_nxt;
        pend_cnt_r    <= pend_cnt_nxt;
        pend_fields_r <= pend_fields_nxt;
        wr_ptr_r      <= wr_ptr_r + RES_PTR_W'(nwr);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + RES_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_code_r <= pend_code_nxt;
      pend_off_r  <= pend_off_nxt;
      if (nwr != 2'd0) queue_r[wr_ptr_r] <= res0;
      if (nwr == 2'd2) queue_r[wr_ptr_r + RES_PTR_W'(1)] <= res1;
    end
  end

  res_t head;
  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {6'b0, head.intra_slice, head.quant_scale, head.height_extension,
                       head.width_extension, head.picture_width, head.extension_id,
                       head.code_offset, head.code_value};
  assign out_tuser  = {head.truncated, head.code_kind};
  assign out_tlast  = head.last_in_run;

endmodule

FILE: rtl/m2sc_checker.sv
// port-level checks for the mpeg2 start code scanner, bound to the top level
module m2sc_checker
  import m2sc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // queue comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("result beat or stall right after reset");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // kind agrees with the code byte for sequence headers and extensions
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser[2:0] == KIND_SEQ_HDR) == (out_tdata[7:0] == CODE_SEQ_HDR)) &&
                   ((out_tuser[2:0] == KIND_EXT) == (out_tdata[7:0] == CODE_EXT)))
    else $error("code kind does not match code byte");

  // width only for a sequence header, slice fields only for a key slice
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] == KIND_SEQ_HDR || out_tdata[39:28] == 12'd0) &&
                   (out_tuser[2:0] == KIND_SLICE || out_tdata[49:44] == 6'd0))
    else $error("field set for the wrong kind");

endmodule

bind mpeg2_start_code_scanner m2sc_checker u_m2sc_checker (.*);
